@@ hw/rtl/mpbf_pkg.sv @@
// ----------------------------------------------------------------------------
// mpbf_pkg
// Shared types, codes and defaults for the multi-pipe byte FIFO manager.
// ----------------------------------------------------------------------------
`default_nettype none

package mpbf_pkg;

    localparam int NUM_SLOTS_DEF  = 16;
    localparam int RING_BYTES_DEF = 1024;
    localparam int KEY_BITS_DEF   = 16;

    localparam int FIRST_AUTO_KEY = 10;
    localparam int SLOT_W_MAX     = 6;   // enough for 64 slots
    localparam int CMDQ_DEPTH     = 2;

    // function codes
    localparam logic [2:0] FN_CREATE  = 3'd0;
    localparam logic [2:0] FN_AUTO    = 3'd1;
    localparam logic [2:0] FN_DESTROY = 3'd2;
    localparam logic [2:0] FN_EOF     = 3'd3;
    localparam logic [2:0] FN_WRITE   = 3'd4;
    localparam logic [2:0] FN_READ    = 3'd5;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_ID   = 3'd1;
    localparam logic [2:0] ST_NO_SPACE = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;
    localparam logic [2:0] ST_EOF      = 3'd5;

    typedef enum logic [2:0] {
        OP_REPLY,
        OP_CLEAR,
        OP_EOF,
        OP_WRITE,
        OP_READ
    } t_op;

    typedef struct packed {
        t_op                   op;
        logic [SLOT_W_MAX-1:0] slot;
        logic [7:0]            data;
        logic [2:0]            status;
        logic [15:0]           new_key;
        logic                  last;
    } t_cmd;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  data;
        logic [15:0] new_key;
        logic        last;
    } t_res;

endpackage

`default_nettype wire

@@ hw/rtl/mpbf_front.sv @@
// ----------------------------------------------------------------------------
// mpbf_front
// Takes items, resolves keys against the slot table, owns the key table and
// hands classified commands to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mpbf_front #(
    parameter int NUM_SLOTS = mpbf_pkg::NUM_SLOTS_DEF,
    parameter int KEY_BITS  = mpbf_pkg::KEY_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire logic [2:0]  i_func,
    input  wire logic [15:0] i_pipe_key,
    input  wire logic [7:0]  i_data_in,
    input  wire logic        i_last,
    input  wire logic        i_q_full,
    output logic             o_full,
    output logic             o_q_push,
    output mpbf_pkg::t_cmd   o_q_cmd
);
    import mpbf_pkg::*;

    localparam int SW = $clog2(NUM_SLOTS);
    localparam int KW = KEY_BITS;

    typedef enum logic [1:0] {F_IDLE, F_LOOK, F_SRCH} t_fstate;

    t_fstate           r_state, n_state;
    logic [2:0]        r_func;
    logic [KW-1:0]     r_key;
    logic [7:0]        r_data;
    logic              r_last;
    logic [KW-1:0]     r_cand, n_cand;
    logic [KW-1:0]     r_slot_key [NUM_SLOTS];

    logic [KW-1:0]     in_key;
    logic [KW-1:0]     cmp_key;
    logic [15:0]       cand_out;
    logic [NUM_SLOTS-1:0] hit_vec, free_vec;
    logic              any_hit, any_free;
    logic [SW-1:0]     hit_idx, free_idx;
    logic              claim, drop;

    generate
        if (KW >= 16) begin : g_wide
            assign in_key   = KW'(i_pipe_key);
            assign cand_out = r_cand[15:0];
        end else begin : g_narrow
            assign in_key   = i_pipe_key[KW-1:0];
            assign cand_out = 16'(r_cand);
        end
    endgenerate

    assign cmp_key = (r_state == F_SRCH) ? r_cand : r_key;

    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            hit_vec[i]  = (r_slot_key[i] == cmp_key) && (cmp_key != '0);
            free_vec[i] = (r_slot_key[i] == '0);
            if (hit_vec[i])  hit_idx  = SW'(i);
            if (free_vec[i]) free_idx = SW'(i);
        end
    end

    assign any_hit  = |hit_vec;
    assign any_free = |free_vec;

    assign o_full = (r_state != F_IDLE) || i_q_full;

    always_comb begin
        n_state  = r_state;
        n_cand   = r_cand;
        claim    = 1'b0;
        drop     = 1'b0;
        o_q_push = 1'b0;
        o_q_cmd  = '{op: OP_REPLY, slot: '0, data: r_data, status: ST_BAD_ID,
                     new_key: '0, last: r_last};
        case (r_state)
            F_IDLE: begin
                if (i_push && !o_full) n_state = F_LOOK;
            end
            F_LOOK: begin
                n_state  = F_IDLE;
                o_q_push = 1'b1;
                case (r_func)
                    FN_CREATE: begin
                        if (r_key == '0)    o_q_cmd.status = ST_BAD_ID;
                        else if (!any_free) o_q_cmd.status = ST_NO_SPACE;
                        else if (any_hit)   o_q_cmd.status = ST_BAD_ID;
                        else begin
                            claim          = 1'b1;
                            o_q_cmd.op     = OP_CLEAR;
                            o_q_cmd.slot   = SLOT_W_MAX'(free_idx);
                            o_q_cmd.status = ST_OK;
                        end
                    end
                    FN_AUTO: begin
                        if (!any_free) o_q_cmd.status = ST_NO_SPACE;
                        else begin
                            o_q_push = 1'b0;
                            n_state  = F_SRCH;
                            n_cand   = KW'(FIRST_AUTO_KEY);
                        end
                    end
                    FN_DESTROY, FN_EOF, FN_WRITE, FN_READ: begin
                        if (any_hit) begin
                            o_q_cmd.slot   = SLOT_W_MAX'(hit_idx);
                            o_q_cmd.status = ST_OK;
                            case (r_func)
                                FN_DESTROY: begin
                                    drop       = 1'b1;
                                    o_q_cmd.op = OP_CLEAR;
                                end
                                FN_EOF:   o_q_cmd.op = OP_EOF;
                                FN_WRITE: o_q_cmd.op = OP_WRITE;
                                default:  o_q_cmd.op = OP_READ;
                            endcase
                        end
                    end
                    default: ;
                endcase
            end
            F_SRCH: begin
                // one candidate key per cycle; a free one is bound to turn up
                if (any_hit) n_cand = r_cand + 1'b1;
                else begin
                    claim           = 1'b1;
                    o_q_push        = 1'b1;
                    n_state         = F_IDLE;
                    o_q_cmd.op      = OP_CLEAR;
                    o_q_cmd.slot    = SLOT_W_MAX'(free_idx);
                    o_q_cmd.status  = ST_OK;
                    o_q_cmd.new_key = cand_out;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_cand  <= '0;
            for (int i = 0; i < NUM_SLOTS; i++) r_slot_key[i] <= '0;
        end else begin
            r_state <= n_state;
            r_cand  <= n_cand;
            if (claim) r_slot_key[free_idx] <= cmp_key;
            if (drop)  r_slot_key[hit_idx]  <= '0;
            if (r_state == F_IDLE && i_push && !o_full) begin
                r_func <= i_func;
                r_key  <= in_key;
                r_data <= i_data_in;
                r_last <= i_last;
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/mpbf_cmdq.sv @@
// ----------------------------------------------------------------------------
// mpbf_cmdq
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module mpbf_cmdq (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  mpbf_pkg::t_cmd      i_cmd,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_empty,
    output mpbf_pkg::t_cmd      o_cmd
);
    import mpbf_pkg::*;

    localparam int PW = $clog2(CMDQ_DEPTH);
    localparam int CW = $clog2(CMDQ_DEPTH + 1);

    t_cmd          r_mem [CMDQ_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(CMDQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_mem[r_wp] <= i_cmd;
                r_wp <= (r_wp == PW'(CMDQ_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) r_rp <= (r_rp == PW'(CMDQ_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + CW'(do_push) - CW'(do_pop);
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/mpbf_back.sv @@
// ----------------------------------------------------------------------------
// mpbf_back
// Executes commands: ring pointers, fill counts, eof flags, the byte store
// and a two-entry result buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module mpbf_back #(
    parameter int NUM_SLOTS  = mpbf_pkg::NUM_SLOTS_DEF,
    parameter int RING_BYTES = mpbf_pkg::RING_BYTES_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_q_empty,
    input  mpbf_pkg::t_cmd i_q_cmd,
    output logic           o_q_pop,
    input  wire logic      i_pop,
    output logic           o_empty,
    output mpbf_pkg::t_res o_res
);
    import mpbf_pkg::*;

    localparam int SW    = $clog2(NUM_SLOTS);
    localparam int PW    = $clog2(RING_BYTES);
    localparam int CW    = $clog2(RING_BYTES + 1);
    localparam int DEPTH = NUM_SLOTS * RING_BYTES;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [1:0] {B_IDLE, B_EXEC, B_RDW} t_bstate;

    t_bstate       r_state, n_state;
    t_cmd          r_cmd;
    logic [PW-1:0] r_head [NUM_SLOTS];
    logic [PW-1:0] r_tail [NUM_SLOTS];
    logic [CW-1:0] r_cnt  [NUM_SLOTS];
    logic          r_eof  [NUM_SLOTS];
    t_res          r_ob   [2];
    logic          r_ob_wp, r_ob_rp;
    logic [1:0]    r_ob_cnt;
    logic [7:0]    r_rd_data;
    logic [7:0]    mem [DEPTH];

    logic [SW-1:0] s;
    logic [CW-1:0] cur_cnt;
    logic [PW-1:0] cur_head, cur_tail, nxt_head, nxt_tail;
    logic          is_full, is_empty;
    logic [AW-1:0] mem_addr;
    logic          mem_we, mem_re;
    logic          res_push, out_pop;
    t_res          res;

    assign s        = r_cmd.slot[SW-1:0];
    assign cur_cnt  = r_cnt[s];
    assign cur_head = r_head[s];
    assign cur_tail = r_tail[s];
    assign nxt_head = (cur_head == PW'(RING_BYTES - 1)) ? '0 : cur_head + 1'b1;
    assign nxt_tail = (cur_tail == PW'(RING_BYTES - 1)) ? '0 : cur_tail + 1'b1;
    assign is_full  = (cur_cnt == CW'(RING_BYTES));
    assign is_empty = (cur_cnt == '0);
    assign mem_addr = AW'(s) * AW'(RING_BYTES)
                    + AW'((r_cmd.op == OP_WRITE) ? cur_tail : cur_head);

    assign o_empty = (r_ob_cnt == 2'd0);
    assign o_res   = r_ob[r_ob_rp];
    assign out_pop = i_pop && !o_empty;
    assign o_q_pop = (r_state == B_IDLE) && !i_q_empty && (r_ob_cnt != 2'd2);

    always_comb begin
        n_state  = r_state;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        res_push = 1'b0;
        res      = '{status: r_cmd.status, data: 8'd0, new_key: r_cmd.new_key,
                     last: r_cmd.last};
        case (r_state)
            B_IDLE: if (o_q_pop) n_state = B_EXEC;
            B_EXEC: begin
                n_state  = B_IDLE;
                res_push = 1'b1;
                case (r_cmd.op)
                    OP_WRITE: begin
                        if (is_full) res.status = ST_FULL;
                        else mem_we = 1'b1;
                    end
                    OP_READ: begin
                        if (is_empty) res.status = r_eof[s] ? ST_EOF : ST_EMPTY;
                        else begin
                            mem_re   = 1'b1;
                            res_push = 1'b0;
                            n_state  = B_RDW;
                        end
                    end
                    default: ;
                endcase
            end
            B_RDW: begin
                n_state  = B_IDLE;
                res_push = 1'b1;
                res.data = r_rd_data;
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_addr] <= r_cmd.data;
        if (mem_re) r_rd_data <= mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ob_wp  <= 1'b0;
            r_ob_rp  <= 1'b0;
            r_ob_cnt <= 2'd0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_cnt[i]  <= '0;
                r_eof[i]  <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            if (o_q_pop) r_cmd <= i_q_cmd;
            if (r_state == B_EXEC) begin
                case (r_cmd.op)
                    OP_CLEAR: begin
                        r_head[s] <= '0;
                        r_tail[s] <= '0;
                        r_cnt[s]  <= '0;
                        r_eof[s]  <= 1'b0;
                    end
                    OP_EOF: r_eof[s] <= 1'b1;
                    OP_WRITE: if (!is_full) begin
                        r_tail[s] <= nxt_tail;
                        r_cnt[s]  <= cur_cnt + 1'b1;
                    end
                    OP_READ: if (!is_empty) begin
                        r_head[s] <= nxt_head;
                        r_cnt[s]  <= cur_cnt - 1'b1;
                    end
                    default: ;
                endcase
            end
            if (res_push) begin
                r_ob[r_ob_wp] <= res;
                r_ob_wp       <= ~r_ob_wp;
            end
            if (out_pop) r_ob_rp <= ~r_ob_rp;
            r_ob_cnt <= r_ob_cnt + 2'(res_push) - 2'(out_pop);
        end
    end

    a_ob_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ob_cnt != 2'd3) else $error("result buffer overrun");

    a_rd_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == B_RDW |-> $past(mem_re)) else $error("read wait without read");

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (cur_cnt < CW'(RING_BYTES) && !mem_re))
        else $error("write into full ring");

endmodule

`default_nettype wire

@@ hw/rtl/multi_pipe_byte_fifo_manager_core.sv @@
// ----------------------------------------------------------------------------
// multi_pipe_byte_fifo_manager_core
// Table of keyed byte pipes with create, auto create, destroy, eof, write
// and read operations; one result per item.
// ----------------------------------------------------------------------------
// Each item names an operation and a pipe key; exactly one result comes back
// per item, in order. The front end latches an item and, in the next cycle,
// matches its key against all slot keys at once and updates the key table;
// auto create then tries one candidate key per cycle from 10 upward. The back
// end takes commands from a two-entry queue and handles one command at a
// time; a successful read passes through an extra read-wait state, as its
// byte comes out of the registered port of the back end's single byte store.
// Neither end takes a new item before it is through with the last one.
// Results wait in a two-entry buffer so the front keeps taking transfers
// while the consumer stalls, until that buffer and the command queue fill.
// No clearing pass: the byte store is only read where it was written.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_pipe_byte_fifo_manager_core #(
    parameter int NUM_SLOTS  = mpbf_pkg::NUM_SLOTS_DEF,
    parameter int RING_BYTES = mpbf_pkg::RING_BYTES_DEF,
    parameter int KEY_BITS   = mpbf_pkg::KEY_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [2:0]  i_func,
    input  wire logic [15:0] i_pipe_key,
    input  wire logic [7:0]  i_data_in,
    input  wire logic        i_last_of_transfer,
    output logic             empty,
    input  wire logic        pop,
    output logic [2:0]       o_status,
    output logic [7:0]       o_data_out,
    output logic [15:0]      o_new_key,
    output logic             o_last_out
);
    import mpbf_pkg::*;

    logic q_push, q_pop, q_full, q_empty;
    t_cmd front_cmd, back_cmd;
    t_res res;

    // front end: key table and classification
    mpbf_front #(.NUM_SLOTS(NUM_SLOTS), .KEY_BITS(KEY_BITS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_func     (i_func),
        .i_pipe_key (i_pipe_key),
        .i_data_in  (i_data_in),
        .i_last     (i_last_of_transfer),
        .i_q_full   (q_full),
        .o_full     (full),
        .o_q_push   (q_push),
        .o_q_cmd    (front_cmd)
    );

    // decoupling queue
    mpbf_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_cmd   (back_cmd)
    );

    // back end: rings, byte store and result buffer
    mpbf_back #(.NUM_SLOTS(NUM_SLOTS), .RING_BYTES(RING_BYTES)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_cmd   (back_cmd),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_res     (res)
    );

    assign o_status   = res.status;
    assign o_data_out = res.data;
    assign o_new_key  = res.new_key;
    assign o_last_out = res.last;

endmodule

`default_nettype wire
